[sv/pidvdt_pkg.sv]
// ----------------------------------------------------------------------------
// pidvdt_pkg
// Shared widths and register indexes for the variable-step PID controller.
// ----------------------------------------------------------------------------
package pidvdt_pkg;

    localparam int GAIN_WIDTH      = 16;
    localparam int TICK_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    // shared multiplier: 17 x 34 signed
    localparam int MUL_A_WIDTH = GAIN_WIDTH + 1;
    localparam int MUL_B_WIDTH = 34;
    localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;

    // integral is split into two chunks for the gain_i product
    localparam int CHUNK_WIDTH = 32;
    localparam int EXT_WIDTH   = 2 * CHUNK_WIDTH;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_GAIN_P  = 3'd0;
    localparam cfg_index_t REG_GAIN_I  = 3'd1;
    localparam cfg_index_t REG_GAIN_D  = 3'd2;
    localparam cfg_index_t REG_OUT_MIN = 3'd3;
    localparam cfg_index_t REG_OUT_MAX = 3'd4;

endpackage

[sv/pidvdt_in_if.sv]
// ----------------------------------------------------------------------------
// pidvdt_in_if
// Sample channel: setpoint, measurement and elapsed ticks.
// ----------------------------------------------------------------------------
interface pidvdt_in_if
    import pidvdt_pkg::*;
#(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] setpoint;
    logic signed [DATA_WIDTH-1:0] measured;
    logic [TICK_WIDTH-1:0]        elapsed_ticks;

    modport source (output valid, output setpoint, output measured,
                    output elapsed_ticks, input ready);
    modport sink   (input valid, input setpoint, input measured,
                    input elapsed_ticks, output ready);
endinterface

[sv/pidvdt_out_if.sv]
// ----------------------------------------------------------------------------
// pidvdt_out_if
// Result channel: clamped drive value.
// ----------------------------------------------------------------------------
interface pidvdt_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

[sv/pidvdt_cfg_if.sv]
// ----------------------------------------------------------------------------
// pidvdt_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface pidvdt_cfg_if
    import pidvdt_pkg::*;
#(
    parameter int DATA_WIDTH = 16
);
    localparam int CFG_DATA_WIDTH = (DATA_WIDTH > GAIN_WIDTH) ? DATA_WIDTH : GAIN_WIDTH;

    logic                      valid;
    logic                      ready;
    cfg_index_t                index;
    logic [CFG_DATA_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/pid_controller_variable_dt.sv]
// ----------------------------------------------------------------------------
// pid_controller_variable_dt
// PID controller with variable time step, saturating integral, serial
// derivative divide and clamped output. One shared 17x34 multiplier.
// ----------------------------------------------------------------------------
// Sequence: a transferred sample passes PREP, INTEG, ACC_P, ACC_IL, ACC_IH,
//   WAIT_DIV, ISSUE_D, ACC_D and OUT; WAIT_DIV waits for the restoring divider
//   (one quotient bit per cycle) for the derivative. No new sample is taken
//   until the current one has been written to the output register.
// Reset: gains zero, limits at the full drive range, integral and last error
//   zero, output register empty. Register writes are accepted every cycle.
module pid_controller_variable_dt
    import pidvdt_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int SUM_WIDTH  = 40
)(
    input  logic         clk,
    input  logic         rst_n,
    pidvdt_in_if.sink    sample,
    pidvdt_out_if.source result,
    pidvdt_cfg_if.sink   cfg
);

    localparam int ERR_WIDTH  = DATA_WIDTH + 1;
    localparam int DIFF_WIDTH = DATA_WIDTH + 2;
    localparam int INT_WIDTH  = ((SUM_WIDTH > ERR_WIDTH + TICK_WIDTH) ?
                                 SUM_WIDTH : ERR_WIDTH + TICK_WIDTH) + 1;
    localparam int ACC_WIDTH  = ((SUM_WIDTH > DIFF_WIDTH) ? SUM_WIDTH : DIFF_WIDTH)
                                + MUL_A_WIDTH + 1;
    localparam int CNT_WIDTH  = $clog2(DIFF_WIDTH);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PREP     = 4'd1;
    localparam logic [3:0] S_INTEG    = 4'd2;
    localparam logic [3:0] S_ACC_P    = 4'd3;
    localparam logic [3:0] S_ACC_IL   = 4'd4;
    localparam logic [3:0] S_ACC_IH   = 4'd5;
    localparam logic [3:0] S_WAIT_DIV = 4'd6;
    localparam logic [3:0] S_ISSUE_D  = 4'd7;
    localparam logic [3:0] S_ACC_D    = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [3:0]                   state_reg, state_next;

    logic signed [GAIN_WIDTH-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [DATA_WIDTH-1:0] out_min_reg, out_max_reg;

    logic signed [SUM_WIDTH-1:0]  integral_reg;
    logic signed [ERR_WIDTH-1:0]  prev_err_reg;
    logic signed [ERR_WIDTH-1:0]  err_reg;
    logic [TICK_WIDTH-1:0]        dt_reg;

    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic signed [ACC_WIDTH-1:0]  acc_reg;

    logic [DATA_WIDTH:0]          div_quo_reg;
    logic [TICK_WIDTH-1:0]        div_rem_reg;
    logic [CNT_WIDTH-1:0]         div_cnt_reg;
    logic                         div_neg_reg;

    logic signed [DATA_WIDTH-1:0] drive_reg;
    logic                         out_valid_reg;

    logic                         in_xfer, out_free;

    // ---------------------------------------------------------------- config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            out_min_reg <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
            out_max_reg <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_GAIN_P:  gain_p_reg  <= cfg.data[GAIN_WIDTH-1:0];
                REG_GAIN_I:  gain_i_reg  <= cfg.data[GAIN_WIDTH-1:0];
                REG_GAIN_D:  gain_d_reg  <= cfg.data[GAIN_WIDTH-1:0];
                REG_OUT_MIN: out_min_reg <= cfg.data[DATA_WIDTH-1:0];
                REG_OUT_MAX: out_max_reg <= cfg.data[DATA_WIDTH-1:0];
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------ datapath
    assign sample.ready = (state_reg == S_IDLE);
    assign in_xfer      = sample.valid && sample.ready;
    assign out_free     = !out_valid_reg || result.ready;

    // error difference for the derivative
    logic signed [DIFF_WIDTH-1:0] diff, diff_mag;
    assign diff     = DIFF_WIDTH'(err_reg) - DIFF_WIDTH'(prev_err_reg);
    assign diff_mag = diff[DIFF_WIDTH-1] ? -diff : diff;

    // restoring divider step
    logic [TICK_WIDTH:0]          div_trial;
    logic                         div_ge;
    assign div_trial = {div_rem_reg, div_quo_reg[DATA_WIDTH]};
    assign div_ge    = (div_trial >= {1'b0, dt_reg});

    logic signed [DIFF_WIDTH-1:0] deriv;
    assign deriv = div_neg_reg ? -$signed({1'b0, div_quo_reg})
                               :  $signed({1'b0, div_quo_reg});

    // integral split for the gain_i product
    logic signed [EXT_WIDTH-1:0]   int_ext;
    logic signed [CHUNK_WIDTH-1:0] int_hi;
    assign int_ext = EXT_WIDTH'(integral_reg);
    assign int_hi  = int_ext[EXT_WIDTH-1:CHUNK_WIDTH];

    // shared multiplier operand select
    logic signed [MUL_A_WIDTH-1:0] mul_a;
    logic signed [MUL_B_WIDTH-1:0] mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PREP:
            begin
                mul_a = $signed({1'b0, dt_reg});
                mul_b = MUL_B_WIDTH'(err_reg);
            end
            S_INTEG:
            begin
                mul_a = MUL_A_WIDTH'(gain_p_reg);
                mul_b = MUL_B_WIDTH'(err_reg);
            end
            S_ACC_P:
            begin
                mul_a = MUL_A_WIDTH'(gain_i_reg);
                mul_b = $signed({{(MUL_B_WIDTH-CHUNK_WIDTH){1'b0}},
                                 int_ext[CHUNK_WIDTH-1:0]});
            end
            S_ACC_IL:
            begin
                mul_a = MUL_A_WIDTH'(gain_i_reg);
                mul_b = MUL_B_WIDTH'(int_hi);
            end
            S_ISSUE_D:
            begin
                mul_a = MUL_A_WIDTH'(gain_d_reg);
                mul_b = MUL_B_WIDTH'(deriv);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // saturating integral update
    logic signed [INT_WIDTH-1:0] int_sum, int_back;
    logic signed [SUM_WIDTH-1:0] int_trunc, int_next;
    assign int_sum   = INT_WIDTH'(integral_reg) + INT_WIDTH'(prod_reg);
    assign int_trunc = int_sum[SUM_WIDTH-1:0];
    assign int_back  = INT_WIDTH'(int_trunc);

    always_comb
    begin
        if (int_back == int_sum)
            int_next = int_trunc;
        else if (int_sum[INT_WIDTH-1])
            int_next = {1'b1, {(SUM_WIDTH-1){1'b0}}};
        else
            int_next = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end

    // accumulator addend; the upper integral chunk weighs 2^32
    logic signed [ACC_WIDTH-1:0] prod_ext, acc_add;
    assign prod_ext = ACC_WIDTH'(prod_reg);
    assign acc_add  = (state_reg == S_ACC_IH) ? (prod_ext <<< CHUNK_WIDTH) : prod_ext;

    // scale and clamp: limit to out_max first, then raise to out_min
    logic signed [ACC_WIDTH-1:0] y_shift, y_max, y_min, y_hi, y_lo;
    assign y_shift = acc_reg >>> FRAC_BITS;
    assign y_max   = ACC_WIDTH'(out_max_reg);
    assign y_min   = ACC_WIDTH'(out_min_reg);
    assign y_hi    = (y_shift > y_max) ? y_max : y_shift;
    assign y_lo    = (y_hi < y_min) ? y_min : y_hi;

    // ----------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_xfer) state_next = S_PREP;
            S_PREP:     state_next = S_INTEG;
            S_INTEG:    state_next = S_ACC_P;
            S_ACC_P:    state_next = S_ACC_IL;
            S_ACC_IL:   state_next = S_ACC_IH;
            S_ACC_IH:   state_next = S_WAIT_DIV;
            S_WAIT_DIV: if (div_cnt_reg == '0) state_next = S_ISSUE_D;
            S_ISSUE_D:  state_next = S_ACC_D;
            S_ACC_D:    state_next = S_OUT;
            S_OUT:      if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_INTEG)
                integral_reg <= int_next;

            if (state_reg == S_PREP)
                div_cnt_reg <= CNT_WIDTH'(DATA_WIDTH + 1);
            else if (div_cnt_reg != '0)
                div_cnt_reg <= div_cnt_reg - 1'b1;

            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                prev_err_reg  <= err_reg;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (in_xfer)
        begin
            err_reg <= ERR_WIDTH'(sample.setpoint) - ERR_WIDTH'(sample.measured);
            dt_reg  <= (sample.elapsed_ticks == '0) ? TICK_WIDTH'(1) : sample.elapsed_ticks;
        end

        if (state_reg == S_PREP)
        begin
            div_quo_reg <= diff_mag[DATA_WIDTH:0];
            div_rem_reg <= '0;
            div_neg_reg <= diff[DIFF_WIDTH-1];
        end
        else if (div_cnt_reg != '0)
        begin
            div_quo_reg <= {div_quo_reg[DATA_WIDTH-1:0], div_ge};
            div_rem_reg <= div_ge ? TICK_WIDTH'(div_trial - {1'b0, dt_reg})
                                  : div_trial[TICK_WIDTH-1:0];
        end

        case (state_reg)
            S_ACC_P:                      acc_reg <= prod_ext;
            S_ACC_IL, S_ACC_IH, S_ACC_D:  acc_reg <= acc_reg + acc_add;
            default:                      ;
        endcase

        if (state_reg == S_OUT && out_free)
            drive_reg <= y_lo[DATA_WIDTH-1:0];
    end

    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

    // ---------------------------------------------------------- assertions
    a_xfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_PREP)
        else $error("sample transfer did not start the sequence");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ISSUE_D |-> div_cnt_reg == '0)
        else $error("derivative used before the divide finished");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result appeared outside the output step");

    a_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_min_reg <= out_max_reg) |->
            (drive_reg >= out_min_reg && drive_reg <= out_max_reg))
        else $error("drive outside its limits");

endmodule

[test/pidvdt_drive_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pidvdt_drive_check
// Watches the sample, result and register channels of the PID controller,
// keeps its own copy of gains, limits, integral and last error, predicts the
// drive of every accepted sample and compares it with the drive transfers.
// ----------------------------------------------------------------------------
module pidvdt_drive_check
    import pidvdt_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int SUM_WIDTH  = 40
)(
    input  logic  clk,
    input  logic  rst_n,
    pidvdt_in_if  sample,
    pidvdt_out_if result,
    pidvdt_cfg_if cfg,
    output int    drive_errors,
    output int    drives_due
);

    localparam longint SUM_MAX = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    longint kp, ki, kd, lo_lim, hi_lim;
    longint integ, last_err;

    logic [DATA_WIDTH-1:0] drive_due[$];
    logic [DATA_WIDTH-1:0] want;

    // updates the integral and last error as a side effect
    function automatic logic [DATA_WIDTH-1:0] next_drive(
        input logic signed [DATA_WIDTH-1:0] sp,
        input logic signed [DATA_WIDTH-1:0] pv,
        input logic [TICK_WIDTH-1:0]        ticks
    );
        longint dt, e, step, rate, acc, y;
        dt   = (ticks == '0) ? 1 : longint'(ticks);
        e    = longint'(sp) - longint'(pv);
        step = e * dt;
        if (step > 0 && integ > SUM_MAX - step)
            integ = SUM_MAX;
        else if (step < 0 && integ < SUM_MIN - step)
            integ = SUM_MIN;
        else
            integ = integ + step;
        // signed division truncates toward zero
        rate = (e - last_err) / dt;
        // ki * integral stays well inside 64 bits at these widths
        acc  = kp * e + ki * integ + kd * rate;
        y    = acc >>> FRAC_BITS;
        last_err = e;
        if (y > hi_lim)
            y = hi_lim;
        if (y < lo_lim)
            y = lo_lim;
        return y[DATA_WIDTH-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp       = 0;
            ki       = 0;
            kd       = 0;
            lo_lim   = -(longint'(1) <<< (DATA_WIDTH - 1));
            hi_lim   = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
            integ    = 0;
            last_err = 0;
            drive_due.delete();
            drives_due   = 0;
            drive_errors = 0;
        end
        else
        begin
            // a result transfer in the same cycle belongs to an earlier sample
            if (result.valid && result.ready)
            begin
                if (drive_due.size() == 0)
                begin
                    $error("drive: transfer with nothing expected, actual %0d",
                           $signed(result.drive));
                    drive_errors++;
                end
                else
                begin
                    want = drive_due.pop_front();
                    if (result.drive !== want)
                    begin
                        $error("drive mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(result.drive));
                        drive_errors++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_GAIN_P:  kp = longint'($signed(cfg.data[GAIN_WIDTH-1:0]));
                    REG_GAIN_I:  ki = longint'($signed(cfg.data[GAIN_WIDTH-1:0]));
                    REG_GAIN_D:  kd = longint'($signed(cfg.data[GAIN_WIDTH-1:0]));
                    REG_OUT_MIN: lo_lim = longint'($signed(cfg.data[DATA_WIDTH-1:0]));
                    REG_OUT_MAX: hi_lim = longint'($signed(cfg.data[DATA_WIDTH-1:0]));
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready)
                drive_due.push_back(next_drive(sample.setpoint, sample.measured,
                                               sample.elapsed_ticks));
            drives_due = drive_due.size();
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the variable-step PID controller: directed corner samples,
// random samples over several gain and limit settings, integral wind-up in
// both directions and crossed limits, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import pidvdt_pkg::*;

    localparam int DATA_WIDTH    = 16;
    localparam int FRAC_BITS     = 8;
    localparam int SUM_WIDTH     = 40;
    localparam int SETTLE_CYCLES = DATA_WIDTH + 16;
    localparam int HOLD_CYCLES   = 300;

    logic clk = 1'b0;
    logic rst_n;
    int   drive_errors;
    int   drives_due;
    int   tx_idle_pct;
    int   rx_idle_pct;
    bit   hold_rx;

    pidvdt_in_if  #(.DATA_WIDTH(DATA_WIDTH)) sample_if ();
    pidvdt_out_if #(.DATA_WIDTH(DATA_WIDTH)) result_if ();
    pidvdt_cfg_if #(.DATA_WIDTH(DATA_WIDTH)) cfg_if ();

    pid_controller_variable_dt #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .SUM_WIDTH  (SUM_WIDTH)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    pidvdt_drive_check #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .SUM_WIDTH  (SUM_WIDTH)
    ) drive_check_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample_if),
        .result       (result_if),
        .cfg          (cfg_if),
        .drive_errors (drive_errors),
        .drives_due   (drives_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : rx_side
        bit held;
        held            = 1'b0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rx && !held)
            begin
                result_if.ready <= 1'b0;
                held = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if ($urandom_range(0, 99) < rx_idle_pct)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            result_if.ready <= 1'b1;
        end
    end

    // all stimulus tasks are entered and left at a falling edge
    task automatic send_sample(input logic [DATA_WIDTH-1:0] sp,
                               input logic [DATA_WIDTH-1:0] pv,
                               input logic [TICK_WIDTH-1:0] ticks);
        int gap;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 7) : 0;
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid         <= 1'b1;
        sample_if.setpoint      <= sp;
        sample_if.measured      <= pv;
        sample_if.elapsed_ticks <= ticks;
        do
            @(posedge clk);
        while (!sample_if.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= 16'(value);
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
    endtask

    // stop offering samples and wait for every drive still owed
    task automatic drain_samples;
        sample_if.valid <= 1'b0;
        while (drives_due != 0)
            @(negedge clk);
    endtask

    task automatic program_regs(input int kp, input int ki, input int kd,
                                input int lo, input int hi);
        drain_samples();
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_OUT_MIN, lo);
        write_reg(REG_OUT_MAX, hi);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic int pick_gain();
        if ($urandom_range(0, 1) == 0)
            return int'($urandom_range(0, 1024)) - 512;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // mix of wide errors and errors close to zero, elapsed from zero to full
    task automatic random_samples(input int count);
        logic [DATA_WIDTH-1:0] sp, pv;
        logic [TICK_WIDTH-1:0] ticks;
        for (int n = 0; n < count; n++)
        begin
            sp = DATA_WIDTH'($urandom);
            case ($urandom_range(0, 3))
                0:       pv = DATA_WIDTH'($urandom);
                1:       pv = sp + DATA_WIDTH'($urandom_range(0, 64)) - DATA_WIDTH'(32);
                2:       pv = sp;
                default: pv = sp - DATA_WIDTH'($urandom_range(0, 1000));
            endcase
            case ($urandom_range(0, 4))
                0:       ticks = '0;
                1:       ticks = TICK_WIDTH'(1);
                2:       ticks = TICK_WIDTH'($urandom_range(2, 16));
                3:       ticks = TICK_WIDTH'($urandom);
                default: ticks = '1;
            endcase
            send_sample(sp, pv, ticks);
        end
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        sample_if.valid         = 1'b0;
        sample_if.setpoint      = '0;
        sample_if.measured      = '0;
        sample_if.elapsed_ticks = '0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = REG_GAIN_P;
        cfg_if.data             = '0;
        tx_idle_pct             = 20;
        rx_idle_pct             = 20;
        hold_rx                 = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset gains: drive stays at zero
        random_samples(4);

        // directed corners
        program_regs(256, 16, 256, -32768, 32767);
        send_sample(16'sd0, 16'sd0, 16'd0);
        send_sample(16'sd100, 16'sd0, 16'd0);
        send_sample(16'sd100, 16'sd0, 16'd1);
        send_sample(16'sh7FFF, 16'sh8000, 16'd1);
        send_sample(16'sh8000, 16'sh7FFF, 16'd1);
        send_sample(16'sh8000, 16'sh7FFF, 16'hFFFF);
        send_sample(16'sh7FFF, 16'sh8000, 16'hFFFF);
        send_sample(16'sd0, 16'sd0, 16'd1);
        // derivative rounding toward zero, both signs
        send_sample(16'sd0, 16'sd7, 16'd2);
        send_sample(16'sd0, -16'sd7, 16'd2);
        send_sample(16'sd0, -16'sd8, 16'd3);
        send_sample(16'sd0, 16'sd5, 16'd3);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'd100);
        send_sample(16'sh8000, 16'sh8000, 16'd0);
        send_sample(16'sd1, 16'sd0, 16'hFFFF);
        send_sample(-16'sd1, 16'sd0, 16'hFFFF);
        send_sample(16'sd0, 16'sd1, 16'd1);

        tx_idle_pct = 25;
        rx_idle_pct = 25;
        for (int k = 0; k < 3; k++)
        begin
            program_regs(pick_gain(), pick_gain(), pick_gain(),
                         -int'($urandom_range(0, 32768)), int'($urandom_range(0, 32767)));
            if (k == 0)
            begin
                // result side holds off while samples keep coming
                @(posedge clk);
                hold_rx = 1'b1;
                @(negedge clk);
            end
            random_samples(120);
        end

        // integral wind-up to both saturation limits
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        program_regs(0, 1, 0, -32768, 32767);
        for (int k = 0; k < 170; k++)
            send_sample(16'sh7FFF, 16'sh8000, 16'($urandom_range(60000, 65535)));
        for (int k = 0; k < 300; k++)
            send_sample(16'sh8000, 16'sh7FFF, 16'($urandom_range(60000, 65535)));
        random_samples(50);

        // extreme gains
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(-32768, -32768, -32768, -32768, 32767);
        random_samples(100);
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        program_regs(32767, 32767, 32767, -32768, 32767);
        random_samples(100);

        // crossed limits: the lower limit wins
        tx_idle_pct = 15;
        rx_idle_pct = 15;
        program_regs(300, 5, 100, 500, -500);
        random_samples(100);
        program_regs(0, 0, 0, 32767, -32768);
        random_samples(10);

        // last part without idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(200, 2, 150, -20000, 20000);
        random_samples(200);

        drain_samples();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (drive_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[pid_controller_variable_dt.f]
sv/pidvdt_pkg.sv
sv/pidvdt_in_if.sv
sv/pidvdt_out_if.sv
sv/pidvdt_cfg_if.sv
sv/pid_controller_variable_dt.sv
test/pidvdt_drive_check.sv
test/tb_top.sv
